// ===== design/pnrf_pkg.sv =====
// Shared types, constants and helper functions for the polynomial Newton root finder.
package pnrf_pkg;

   localparam int MaxCoeffs = 16;
   localparam int IdxW      = $clog2(MaxCoeffs);
   localparam int QW        = 48;
   localparam int CountW    = 5;
   localparam int TolW      = 32;
   localparam int IterW     = 8;
   localparam int CsrAddrW  = 2;
   localparam int CsrDataW  = 32;

   localparam logic [CsrAddrW-1:0] CSR_COEFF_COUNT = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_TOLERANCE   = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_MAX_ITER    = 2'd2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_SOLVE = 1'b1;

   localparam logic signed [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};
   localparam logic signed [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};

   // Saturate a wider signed value to the Q16.32 range.
   function automatic logic signed [QW-1:0] sat_q(input logic signed [QW+1:0] v);
      logic signed [QW+1:0] hi;
      logic signed [QW+1:0] lo;
      hi = {{2{1'b0}}, QMax};
      lo = {{2{1'b1}}, QMin};
      if (v > hi)      sat_q = QMax;
      else if (v < lo) sat_q = QMin;
      else             sat_q = v[QW-1:0];
   endfunction

   // Apply a sign to a 64-bit magnitude and saturate to the Q16.32 range.
   function automatic logic signed [QW-1:0] sign_sat(input logic [63:0] m,
                                                     input logic neg);
      logic [63:0] lim;
      lim = 64'd1 << (QW-1);
      if (neg) begin
         if (m > lim) sign_sat = QMin;
         else         sign_sat = QW'(-m);
      end else begin
         if (m >= lim) sign_sat = QMax;
         else          sign_sat = QW'(m);
      end
   endfunction

   function automatic logic [QW-1:0] mag_q(input logic signed [QW-1:0] v);
      mag_q = v[QW-1] ? QW'(-v) : v;
   endfunction

endpackage

// ===== design/pnrf_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module pnrf_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/pnrf_mul.sv =====
// Sequential Q16.32 saturating multiplier built from 48x16 partial products.
module pnrf_mul
   import pnrf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [QW-1:0] a,
   input  logic signed [QW-1:0] b,
   output logic                 done,
   output logic signed [QW-1:0] prod
);
   // The magnitude of a is multiplied by the magnitude of b, one 16-bit chunk of |b| at a time.
   logic [QW-1:0]  ma_ff, ma_in;
   logic [QW-1:0]  mb_ff, mb_in;
   logic [95:0]    acc_ff, acc_in;
   logic [1:0]     step_ff, step_in;
   logic           busy_ff, busy_in;
   logic           neg_ff, neg_in;
   logic           done_ff, done_in;
   logic [QW-1:0]  prod_ff, prod_in;
   logic [15:0]    chunk;
   logic [63:0]    part;
   logic [63:0]    shifted;

   always_comb begin
      chunk = mb_ff[16*step_ff +: 16];
      part  = {16'd0, ma_ff} * {48'd0, chunk};
   end

   always_comb begin
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      prod_in = prod_ff;
      shifted = 64'd0;
      if (start) begin
         ma_in   = mag_q(a);
         mb_in   = mag_q(b);
         neg_in  = a[QW-1] ^ b[QW-1];
         acc_in  = 96'd0;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + ({32'd0, part} << (16*step_ff));
         if (step_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (acc_in[95:95] != 1'b0 || acc_in[94:32] > {1'b0, {62{1'b1}}}) begin
               shifted = 64'd1 << 63;
            end else begin
               shifted = acc_in[95:32];
            end
            prod_in = sign_sat(shifted, neg_ff);
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;
endmodule

// ===== design/pnrf_div.sv =====
// Restoring Q16.32 divider producing one quotient bit per cycle.
module pnrf_div
   import pnrf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [QW-1:0] a,
   input  logic signed [QW-1:0] b,
   output logic                 done,
   output logic signed [QW-1:0] quot
);
   // The dividend is |a| << 32, 80 bits; quotient bits above bit 47 only saturate.
   localparam int NumW = QW + 32;

   logic [NumW-1:0] num_ff, num_in;
   logic [QW:0]     rem_ff, rem_in;
   logic [QW-1:0]   den_ff, den_in;
   logic [NumW-1:0] q_ff, q_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            neg_ff, neg_in;
   logic            done_ff, done_in;
   logic [QW-1:0]   quot_ff, quot_in;
   logic [QW:0]     trial;
   logic [63:0]     qm;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      quot_in = quot_ff;
      trial   = {rem_ff[QW-1:0], num_ff[NumW-1]};
      qm      = 64'd0;
      if (start) begin
         num_in  = {mag_q(a), 32'd0};
         den_in  = mag_q(b);
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = 7'(NumW);
         neg_in  = a[QW-1] ^ b[QW-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // Integer part of 2^16 or more saturates.
            if (q_in[NumW-1:QW] != '0) qm = 64'd1 << 63;
            else                       qm = {16'd0, q_in[QW-1:0]};
            quot_in = sign_sat(qm, neg_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

// ===== design/polynomial_newton_root_finder_top.sv =====
// Top level of the polynomial Newton root finder: sequencer, store and shared units.
//
//   Channel   Direction  Handshake        Payload
//   req       in         req_valid/stall  req_func, req_coeff_index, req_value
//   rsp       out        rsp_valid/stall  rsp_root, rsp_found
//   csr       in         csr_wr_en        csr_index, csr_data
//
// Per round, a Horner pass runs over m terms (m = n for p, n-1 for p'): each term is
// a store read, a product on the shared multiplier and an add. The divide step is
// the check, 80 restoring quotient bits and the hand-off.
// Reset is synchronous; the store holds no reset value. A stalled result beat stays
// in the output register; the next result then holds the block until it leaves.
module polynomial_newton_root_finder_top
   import pnrf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [3:0]           req_coeff_index,
   input  logic signed [QW-1:0] req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [QW-1:0] rsp_root,
   output logic                 rsp_found,
   input  logic                 csr_wr_en,
   input  logic [CsrAddrW-1:0]  csr_index,
   input  logic [CsrDataW-1:0]  csr_data
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_RD0, ST_LOAD0, ST_RDI, ST_MUL, ST_WMUL, ST_ADD,
      ST_CHKP, ST_DIVW, ST_OUT
   } state_type;

   state_type             state_ff;
   logic [TolW-1:0]       tol_ff;
   logic [IterW-1:0]      maxit_ff;
   logic [IterW-1:0]      it_ff;
   logic                  deriv_ff;   // current Horner pass is the derivative
   logic [IdxW:0]         i_ff;       // next coefficient index in the pass
   logic [IdxW:0]         n_ff;       // coefficient count clamped
   logic signed [QW-1:0]  x_ff, start_ff, acc_ff, fx_ff, root_ff;
   logic                  found_ff, valid_ff, found_out_ff;
   logic                  mul_start, div_start, mul_done, div_done;
   logic signed [QW-1:0]  mul_b, mul_p, div_q, ram_q;
   logic [IdxW-1:0]       rd_addr;
   logic                  ram_we;
   logic [IdxW:0]         pass_n;
   logic [QW-1:0]         acc_mag;
   logic signed [QW+1:0]  sum;
   logic [5:0]            clamp;

   assign ram_we  = req_valid && !req_stall && req_func == FUNC_WRITE;
   assign rd_addr = i_ff[IdxW-1:0];

   pnrf_ram #(.Width(QW), .Depth(MaxCoeffs)) u_store (
      .clock(clock), .wr_en(ram_we), .wr_addr(req_coeff_index[IdxW-1:0]),
      .wr_data(req_value), .rd_addr(rd_addr), .rd_data(ram_q)
   );

   assign mul_b     = x_ff;
   assign pass_n    = deriv_ff ? n_ff - (IdxW+1)'(1) : n_ff;
   assign mul_start = state_ff == ST_MUL;
   assign acc_mag   = mag_q(acc_ff);

   // A scaled derivative coefficient k*c is formed exactly and then saturated.
   logic signed [QW+IdxW+1:0] scaled;
   always_comb begin
      logic [IdxW:0] k2;
      k2     = n_ff - i_ff - (IdxW+1)'(1);
      scaled = $signed({{(IdxW+2){ram_q[QW-1]}}, ram_q}) * $signed({1'b0, k2});
   end
   logic signed [QW-1:0] scaled_sat;
   always_comb begin
      if (scaled > $signed({{(IdxW+2){1'b0}}, QMax}))      scaled_sat = QMax;
      else if (scaled < $signed({{(IdxW+2){1'b1}}, QMin})) scaled_sat = QMin;
      else                                                 scaled_sat = scaled[QW-1:0];
   end
   logic signed [QW-1:0] term;
   assign term = deriv_ff ? scaled_sat : ram_q;
   assign sum  = {{2{mul_p[QW-1]}}, mul_p} + {{2{term[QW-1]}}, term};

   pnrf_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(acc_ff), .b(mul_b),
      .done(mul_done), .prod(mul_p)
   );

   assign div_start = state_ff == ST_CHKP && deriv_ff && acc_ff != '0
                      && acc_mag >= {16'd0, tol_ff};
   pnrf_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .a(fx_ff), .b(acc_ff),
      .done(div_done), .quot(div_q)
   );

   assign clamp = csr_data[CountW-1:0] == '0 ? 6'd1 :
                  ({1'b0, csr_data[CountW-1:0]} > 6'(MaxCoeffs) ? 6'(MaxCoeffs)
                                                       : {1'b0, csr_data[CountW-1:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= (IdxW+1)'(1);
         tol_ff   <= TolW'(4295);
         maxit_ff <= IterW'(100);
         valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COEFF_COUNT: n_ff     <= clamp[IdxW:0];
               CSR_TOLERANCE:   tol_ff   <= csr_data[TolW-1:0];
               CSR_MAX_ITER:    maxit_ff <= csr_data[IterW-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_stall && req_func == FUNC_SOLVE) begin
                  x_ff     <= req_value;
                  start_ff <= req_value;
                  it_ff    <= '0;
                  found_ff <= 1'b0;
                  if (maxit_ff == '0) begin
                     state_ff <= ST_OUT;
                  end else begin
                     deriv_ff <= 1'b0;
                     i_ff     <= '0;
                     state_ff <= ST_RD0;
                  end
               end
            end
            ST_RD0: state_ff <= ST_LOAD0;
            ST_LOAD0: begin
               if (pass_n == '0) begin
                  acc_ff   <= '0;
                  state_ff <= ST_CHKP;
               end else begin
                  acc_ff   <= term;
                  i_ff     <= i_ff + (IdxW+1)'(1);
                  state_ff <= (i_ff + (IdxW+1)'(1) >= pass_n) ? ST_CHKP : ST_RDI;
               end
            end
            ST_RDI:  state_ff <= ST_MUL;
            ST_MUL:  state_ff <= ST_WMUL;
            ST_WMUL: if (mul_done) state_ff <= ST_ADD;
            ST_ADD: begin
               acc_ff <= sat_q(sum);
               i_ff   <= i_ff + (IdxW+1)'(1);
               state_ff <= (i_ff + (IdxW+1)'(1) >= pass_n) ? ST_CHKP : ST_RDI;
            end
            ST_CHKP: begin
               if (!deriv_ff) begin
                  if (acc_mag < {16'd0, tol_ff}) begin
                     found_ff <= 1'b1;
                     state_ff <= ST_OUT;
                  end else begin
                     fx_ff    <= acc_ff;
                     deriv_ff <= 1'b1;
                     i_ff     <= '0;
                     state_ff <= ST_RD0;
                  end
               end else if (div_start) begin
                  state_ff <= ST_DIVW;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_DIVW: begin
               if (div_done) begin
                  x_ff     <= sat_q({{2{x_ff[QW-1]}}, x_ff} - {{2{div_q[QW-1]}}, div_q});
                  it_ff    <= it_ff + IterW'(1);
                  deriv_ff <= 1'b0;
                  i_ff     <= '0;
                  state_ff <= (it_ff + IterW'(1) >= maxit_ff) ? ST_OUT : ST_RD0;
               end
            end
            ST_OUT: begin
               if (!valid_ff || !rsp_stall) begin
                  valid_ff     <= 1'b1;
                  root_ff      <= found_ff ? x_ff : start_ff;
                  found_out_ff <= found_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (valid_ff && !rsp_stall && !(state_ff == ST_OUT)) valid_ff <= 1'b0;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = valid_ff;
   assign rsp_root  = root_ff;
   assign rsp_found = found_out_ff;
endmodule

// ===== design/pnrf_checker.sv =====
// Port-level checker for the polynomial Newton root finder, bound to the top level.
module pnrf_checker
   import pnrf_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_func,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic signed [QW-1:0] rsp_root
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_root))
      else $error("stalled result beat changed");

   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == FUNC_SOLVE |=> req_stall)
      else $error("request taken during a solve");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == FUNC_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("coefficient write produced a result");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind polynomial_newton_root_finder_top pnrf_checker u_pnrf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_func(req_func), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_root(rsp_root)
);
